[design/normal_cdf_approximation_defines.svh]
// ----------------------------------------------------------------------------
// normal cdf assertion macros
// shared concurrent assertion forms, clocked on i_clk and quiet in reset
// ----------------------------------------------------------------------------
`ifndef NORMAL_CDF_APPROXIMATION_DEFINES_SVH
`define NORMAL_CDF_APPROXIMATION_DEFINES_SVH

// same-cycle implication
`define NCDF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NCDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ncdf_pkg.sv]
// ----------------------------------------------------------------------------
// ncdf_pkg
// constants and types shared by the normal cdf pipeline
// ----------------------------------------------------------------------------
package ncdf_pkg;

    localparam int SB_W         = 33;
    localparam int DIV_STEPS    = 32;
    localparam int HORNER_STEPS = 12;
    localparam int POLY_ORDER   = 5;
    localparam int RECIP_SHIFT  = 36;

    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [31:0] HALF_Q31 = 32'h4000_0000;
    localparam logic [31:0] ZCAP_Q28 = 32'h8000_0000;
    localparam logic [33:0] WCAP_Q28 = 34'(64'd22 << 28);
    localparam logic [27:0] LN2_Q28  = 28'd186065279;

    // 0.2316419 in q0.32
    localparam logic [29:0] A_Q32 =
        30'((64'd2316419 * 64'h1_0000_0000 + 64'd5000000) / 64'd10000000);

    // polynomial coefficients in q1.31, degree 1 to 5
    localparam logic [31:0] COEF_Q31 [1:5] = '{
        32'((64'd1274147 * 64'h8000_0000 + 64'd5000000) / 64'd10000000),
        32'((64'd1422483 * 64'h8000_0000 + 64'd5000000) / 64'd10000000),
        32'((64'd7107068 * 64'h8000_0000 + 64'd5000000) / 64'd10000000),
        32'((64'd7265759 * 64'h8000_0000 + 64'd5000000) / 64'd10000000),
        32'((64'd5307027 * 64'h8000_0000 + 64'd5000000) / 64'd10000000)
    };

    // ceil(2^36 / n), exact reciprocal for 32-bit dividends
    localparam logic [36:0] RECIP [1:12] = '{
        37'((64'd68719476736 + 64'd0) / 64'd1),
        37'((64'd68719476736 + 64'd1) / 64'd2),
        37'((64'd68719476736 + 64'd2) / 64'd3),
        37'((64'd68719476736 + 64'd3) / 64'd4),
        37'((64'd68719476736 + 64'd4) / 64'd5),
        37'((64'd68719476736 + 64'd5) / 64'd6),
        37'((64'd68719476736 + 64'd6) / 64'd7),
        37'((64'd68719476736 + 64'd7) / 64'd8),
        37'((64'd68719476736 + 64'd8) / 64'd9),
        37'((64'd68719476736 + 64'd9) / 64'd10),
        37'((64'd68719476736 + 64'd10) / 64'd11),
        37'((64'd68719476736 + 64'd11) / 64'd12)
    };

    // one stage of the polynomial pipe
    typedef struct packed {
        logic        neg;
        logic [62:0] zz;
        logic [31:0] t;
        logic [31:0] p;
        logic [34:0] acc;
        logic [63:0] prod;
        logic [63:0] tp;
    } t_poly;

endpackage

[design/normal_cdf_approximation.sv]
// ----------------------------------------------------------------------------
// normal_cdf_approximation
// cumulative normal probability by the five-term rational approximation
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready carry sample and mean in q16.16 and
//   standard deviation in q15.16; a transaction happens when both are high
//   output channel: o_out_valid / i_out_ready carry the probability in q1.31
//   throughput: one transaction per cycle while o_in_ready is high; every stage is a
//   register and the two long divisions (z and t) are 32-stage bit-per-stage dividers
//   stall: a full output register plus a one-entry skid buffer decouple the
//   sides; when the skid buffer fills the whole pipe freezes, o_in_ready
//   drops, and nothing in flight is lost or repeated
//   reset: synchronous active-low i_rst_n clears all valid bits and the
//   output/skid flags; data registers keep garbage that is never shown
//   stages: standardize, divide, t prep, divide, polynomial, exp, combine
// ----------------------------------------------------------------------------
module normal_cdf_approximation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_sample_value,
    input  logic signed [31:0] i_mean_value,
    input  logic        [30:0] i_std_dev,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic        [31:0] o_probability
);
    import ncdf_pkg::*;

`include "normal_cdf_approximation_defines.svh"

    // global pipe advance, frozen only while the skid buffer is full
    logic w_adv;

    // input register
    logic        r_in_v;
    logic [31:0] r_s;
    logic [31:0] r_m;
    logic [30:0] r_sd;

    // difference and magnitude
    logic [32:0] w_d;
    logic        r_d_v;
    logic        r_d_neg;
    logic [32:0] r_d_mag;
    logic [30:0] r_d_sd;

    // first divider: |z| in q4.28
    logic            d1_v;
    logic [31:0]     d1_quo;
    logic            d1_ovf;
    logic [SB_W-1:0] d1_sb;

    // z saturation, a|z| product, denominator
    logic        r_z_v;
    logic        r_z_neg;
    logic [31:0] r_z;
    logic        r_az_v;
    logic        r_az_neg;
    logic [31:0] r_az_z;
    logic [61:0] r_az_prod;
    logic [29:0] w_az;
    logic        r_den_v;
    logic        r_den_neg;
    logic [31:0] r_den_z;
    logic [29:0] r_den;

    // second divider: t in q1.31
    logic            d2_v;
    logic [31:0]     d2_quo;
    logic            d2_ovf;
    logic [SB_W-1:0] d2_sb;

    // polynomial pipe
    t_poly pb   [0:POLY_ORDER];
    logic  pb_v [0:POLY_ORDER];
    t_poly pa   [1:POLY_ORDER];
    logic  pa_v [1:POLY_ORDER];
    t_poly n_pb0;
    logic [31:0] w_poly;

    // exp unit
    logic            x_v;
    logic [31:0]     x_exp;
    logic [SB_W-1:0] x_sb;

    // combine
    logic        r_f1_v;
    logic        r_f1_neg;
    logic [63:0] r_f1_prod;
    logic [32:0] w_pe;
    logic [31:0] w_res;
    logic        r_f2_v;
    logic [31:0] r_f2_res;

    // output register and skid buffer
    logic        r_ov;
    logic [31:0] r_od;
    logic        r_sv;
    logic [31:0] r_skd;

    assign w_adv      = ~r_sv;
    assign o_in_ready = w_adv;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_d_v   <= 1'b0;
            r_z_v   <= 1'b0;
            r_az_v  <= 1'b0;
            r_den_v <= 1'b0;
            pb_v[0] <= 1'b0;
            r_f1_v  <= 1'b0;
            r_f2_v  <= 1'b0;
        end else if (w_adv) begin
            r_in_v  <= i_in_valid;
            r_d_v   <= r_in_v;
            r_z_v   <= d1_v;
            r_az_v  <= r_z_v;
            r_den_v <= r_az_v;
            pb_v[0] <= d2_v;
            r_f1_v  <= x_v;
            r_f2_v  <= r_f1_v;
        end
    end

    // standardize: exact 33-bit difference, zero deviation becomes one lsb
    assign w_d = {r_s[31], r_s} - {r_m[31], r_m};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s     <= i_sample_value;
            r_m     <= i_mean_value;
            r_sd    <= i_std_dev;
            r_d_neg <= w_d[32];
            r_d_mag <= w_d[32] ? (33'd0 - w_d) : w_d;
            r_d_sd  <= (r_sd == 31'd0) ? 31'd1 : r_sd;
        end
    end

    // |z| = round(|d| * 2^28 / sd)
    ncdf_div u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_d_v),
        .i_num   (64'({r_d_mag, 28'd0}) + 64'(r_d_sd[30:1])),
        .i_den   ({1'b0, r_d_sd}),
        .i_sb    ({r_d_neg, 32'd0}),
        .o_valid (d1_v),
        .o_quo   (d1_quo),
        .o_ovf   (d1_ovf),
        .o_sb    (d1_sb)
    );

    // den = 1 + round(a |z|) in q4.28
    assign w_az = 30'((r_az_prod + 62'(ONE_Q31)) >> 32);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_z_neg   <= d1_sb[SB_W-1];
            r_z       <= (d1_ovf || (d1_quo > ZCAP_Q28)) ? ZCAP_Q28 : d1_quo;
            r_az_neg  <= r_z_neg;
            r_az_z    <= r_z;
            r_az_prod <= 62'(r_z) * 62'(A_Q32);
            r_den_neg <= r_az_neg;
            r_den_z   <= r_az_z;
            r_den     <= 30'(32'd1 << 28) + w_az;
        end
    end

    // t = round(2^59 / den)
    ncdf_div u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_den_v),
        .i_num   ((64'd1 << 59) + 64'(r_den[29:1])),
        .i_den   ({2'b00, r_den}),
        .i_sb    ({r_den_neg, r_den_z}),
        .o_valid (d2_v),
        .o_quo   (d2_quo),
        .o_ovf   (d2_ovf),
        .o_sb    (d2_sb)
    );

    // polynomial seed: p = t, acc = 0, z^2 carried for the exp unit
    always_comb begin
        n_pb0     = '0;
        n_pb0.neg = d2_sb[SB_W-1];
        n_pb0.zz  = 63'(64'(d2_sb[31:0]) * 64'(d2_sb[31:0]));
        n_pb0.t   = d2_quo;
        n_pb0.p   = d2_quo;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            pb[0] <= n_pb0;
        end
    end

    // each degree: multiply stage, then round and accumulate stage
    for (genvar k = 1; k <= POLY_ORDER; k++) begin : g_poly
        t_poly       n_pa;
        t_poly       n_pb;
        logic [34:0] w_term;

        always_comb begin
            n_pa      = pb[k-1];
            n_pa.prod = 64'(pb[k-1].p) * 64'(pb[k-1].t);
            n_pa.tp   = 64'(COEF_Q31[k]) * 64'(pb[k-1].p);
        end

        assign w_term = 35'((pa[k].tp + 64'(HALF_Q31)) >> 31);

        // odd degrees add, even degrees subtract
        always_comb begin
            n_pb     = pa[k];
            n_pb.p   = 32'((pa[k].prod + 64'(HALF_Q31)) >> 31);
            n_pb.acc = ((k % 2) == 1) ? (pa[k].acc + w_term) : (pa[k].acc - w_term);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                pa_v[k] <= 1'b0;
                pb_v[k] <= 1'b0;
            end else if (w_adv) begin
                pa_v[k] <= pb_v[k-1];
                pb_v[k] <= pa_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                pa[k] <= n_pa;
                pb[k] <= n_pb;
            end
        end
    end

    // negative sum clamps to zero
    assign w_poly = pb[POLY_ORDER].acc[34] ? 32'd0 : pb[POLY_ORDER].acc[31:0];

    // exp(-z^2/2), w = floor(z^2 / 2^29)
    ncdf_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (pb_v[POLY_ORDER]),
        .i_w     (pb[POLY_ORDER].zz[62:29]),
        .i_sb    ({pb[POLY_ORDER].neg, w_poly}),
        .o_valid (x_v),
        .o_exp   (x_exp),
        .o_sb    (x_sb)
    );

    // pe = round(p * e / 2^31), then reflect for non-negative z
    assign w_pe = 33'((r_f1_prod + 64'(HALF_Q31)) >> 31);

    always_comb begin
        if (r_f1_neg) begin
            w_res = (w_pe > {1'b0, ONE_Q31}) ? ONE_Q31 : w_pe[31:0];
        end else begin
            w_res = (w_pe > {1'b0, ONE_Q31}) ? 32'd0 : (ONE_Q31 - w_pe[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_neg  <= x_sb[SB_W-1];
            r_f1_prod <= 64'(x_sb[31:0]) * 64'(x_exp);
            r_f2_res  <= w_res;
        end
    end

    // output register with skid buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) begin
                if (r_sv) begin
                    r_sv <= 1'b0;
                end else if (!(r_f2_v && w_adv)) begin
                    r_ov <= 1'b0;
                end
            end else if (r_f2_v && w_adv) begin
                if (!r_ov) begin
                    r_ov <= 1'b1;
                end else begin
                    r_sv <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ov && i_out_ready) begin
            if (r_sv) begin
                r_od <= r_skd;
            end else if (r_f2_v && w_adv) begin
                r_od <= r_f2_res;
            end
        end else if (r_f2_v && w_adv) begin
            if (!r_ov) begin
                r_od <= r_f2_res;
            end else begin
                r_skd <= r_f2_res;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_probability = r_od;

    // t never overflows since den is at least one
    `NCDF_ASSERT_IMPL(a_t_no_ovf, d2_v, !d2_ovf, "t divider overflow")
    `NCDF_ASSERT_IMPL(a_prob_range, o_out_valid, o_probability <= ONE_Q31, "probability above one")
    `NCDF_ASSERT_IMPL(a_skid_needs_out, r_sv, r_ov, "skid full with empty output")
    `NCDF_ASSERT_NEXT(a_stall_fills_skid, r_ov && !i_out_ready && r_f2_v && w_adv, r_sv, "stalled result dropped")

endmodule

[design/ncdf_div.sv]
// ----------------------------------------------------------------------------
// ncdf_div
// pipelined restoring divider, one quotient bit per stage, 32-bit quotient
// ----------------------------------------------------------------------------
module ncdf_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [63:0]               i_num,
    input  logic [31:0]               i_den,
    input  logic [ncdf_pkg::SB_W-1:0] i_sb,
    output logic                      o_valid,
    output logic [31:0]               o_quo,
    output logic                      o_ovf,
    output logic [ncdf_pkg::SB_W-1:0] o_sb
);
    import ncdf_pkg::*;

    logic            r_v   [0:DIV_STEPS];
    logic [31:0]     r_rem [0:DIV_STEPS];
    logic [31:0]     r_lo  [0:DIV_STEPS];
    logic [31:0]     r_q   [0:DIV_STEPS];
    logic [31:0]     r_den [0:DIV_STEPS];
    logic            r_ovf [0:DIV_STEPS];
    logic [SB_W-1:0] r_sb  [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    // input register; the overflow flag marks a quotient that would not fit in 32 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[63:32];
            r_lo[0]  <= i_num[31:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= (i_num[63:32] >= i_den);
            r_sb[0]  <= i_sb;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [32:0] w_rs;
        logic [32:0] w_diff;
        logic        w_ge;

        assign w_rs   = {r_rem[k-1], r_lo[k-1][31]};
        assign w_ge   = (w_rs >= {1'b0, r_den[k-1]});
        assign w_diff = w_rs - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[31:0] : w_rs[31:0];
                r_lo[k]  <= {r_lo[k-1][30:0], 1'b0};
                r_q[k]   <= {r_q[k-1][30:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_sb[k]  <= r_sb[k-1];
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_quo   = r_q[DIV_STEPS];
    assign o_ovf   = r_ovf[DIV_STEPS];
    assign o_sb    = r_sb[DIV_STEPS];

endmodule

[design/ncdf_exp.sv]
// ----------------------------------------------------------------------------
// ncdf_exp
// pipelined exp(-w), w in q.28, result in q1.31, range reduction by ln2
// ----------------------------------------------------------------------------
module ncdf_exp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [33:0]               i_w,
    input  logic [ncdf_pkg::SB_W-1:0] i_sb,
    output logic                      o_valid,
    output logic [31:0]               o_exp,
    output logic [ncdf_pkg::SB_W-1:0] o_sb
);
    import ncdf_pkg::*;

    typedef struct packed {
        logic [30:0]     r31;
        logic [4:0]      k;
        logic            sat;
        logic [SB_W-1:0] sb;
    } t_hc;

    logic            r_e0_v;
    logic [33:0]     r_e0_w;
    logic [4:0]      r_e0_k;
    logic            r_e0_sat;
    logic [SB_W-1:0] r_e0_sb;
    logic [4:0]      n_e0_k;

    logic            h_v [0:HORNER_STEPS];
    logic [31:0]     h_e [0:HORNER_STEPS];
    t_hc             h_c [0:HORNER_STEPS];

    logic [33:0]     w_r;
    logic [32:0]     w_rnd;
    logic [32:0]     w_sh;

    logic            r_f_v;
    logic [31:0]     r_f_exp;
    logic [SB_W-1:0] r_f_sb;

    // k = floor(w / ln2) capped at 31, thresholds are monotone so the last hit wins
    always_comb begin
        n_e0_k = '0;
        for (int j = 1; j < 32; j++) begin
            if ({1'b0, i_w} >= 35'(j) * 35'(LN2_Q28)) begin
                n_e0_k = 5'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_v <= 1'b0;
            h_v[0] <= 1'b0;
            r_f_v  <= 1'b0;
        end else if (i_en) begin
            r_e0_v <= i_valid;
            h_v[0] <= r_e0_v;
            r_f_v  <= h_v[HORNER_STEPS];
        end
    end

    assign w_r = r_e0_w - 34'(r_e0_k) * 34'(LN2_Q28);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e0_w       <= i_w;
            r_e0_k       <= n_e0_k;
            r_e0_sat     <= (i_w >= WCAP_Q28);
            r_e0_sb      <= i_sb;
            h_e[0]       <= ONE_Q31;
            h_c[0].r31   <= {w_r[27:0], 3'b000};
            h_c[0].k     <= r_e0_k;
            h_c[0].sat   <= r_e0_sat;
            h_c[0].sb    <= r_e0_sb;
        end
    end

    // horner steps for n = 12 down to 1, three stages each
    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
        localparam int N = HORNER_STEPS - j;

        logic        r_a_v;
        logic [62:0] r_a_prod;
        t_hc         r_a_c;
        logic        r_b_v;
        logic [68:0] r_b_mq;
        t_hc         r_b_c;
        logic [31:0] w_x;

        assign w_x = 32'((r_a_prod + 63'(HALF_Q31)) >> 31) + 32'(N / 2);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_v    <= 1'b0;
                r_b_v    <= 1'b0;
                h_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_a_v    <= h_v[j];
                r_b_v    <= r_a_v;
                h_v[j+1] <= r_b_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_prod <= 63'(h_c[j].r31) * 63'(h_e[j]);
                r_a_c    <= h_c[j];
                r_b_mq   <= 69'(w_x) * 69'(RECIP[N]);
                r_b_c    <= r_a_c;
                h_e[j+1] <= ONE_Q31 - r_b_mq[RECIP_SHIFT+31:RECIP_SHIFT];
                h_c[j+1] <= r_b_c;
            end
        end
    end

    // scale by 2^-k with rounding
    assign w_rnd = (h_c[HORNER_STEPS].k == 5'd0) ? 33'd0 :
                   (33'd1 << (h_c[HORNER_STEPS].k - 5'd1));
    assign w_sh  = ({1'b0, h_e[HORNER_STEPS]} + w_rnd) >> h_c[HORNER_STEPS].k;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_exp <= h_c[HORNER_STEPS].sat ? 32'd0 : w_sh[31:0];
            r_f_sb  <= h_c[HORNER_STEPS].sb;
        end
    end

    assign o_valid = r_f_v;
    assign o_exp   = r_f_exp;
    assign o_sb    = r_f_sb;

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// normal cdf testbench
// drives sample, mean and deviation transactions with bursty gaps, stalls the
// result side at random and on a pattern, and checks each probability against a local
// fixed-point model of the approximation
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] sample;
        logic signed [31:0] mean;
        logic        [30:0] sdev;
    } t_point;

    localparam int          PIPE_DRAIN = 200;
    localparam int          MAX_CYCLES = 200000;
    localparam int          N_RANDOM   = 2000;
    localparam longint unsigned Q31_ONE = 64'h8000_0000;
    localparam longint unsigned Q31_HALF = 64'h4000_0000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_sample_value = '0;
    logic signed [31:0] i_mean_value = '0;
    logic        [30:0] i_std_dev = 31'd1;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic        [31:0] o_probability;

    t_point      pending_points[$];
    logic [31:0] expected_probs[$];
    logic        in_took = 1'b0;
    int          mismatches = 0;
    int          cycles = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_timer = 0;

    normal_cdf_approximation dut (.*);

    always #1 i_clk = ~i_clk;

    // fixed-point model of the cdf approximation, one probability per point
    function automatic logic [31:0] cdf_q31(t_point pt);
        longint signed   diff;
        longint unsigned mag, sd, zq28, az, den, tq, pw, term, wq, kq, r31, eq, prod, q, pe;
        longint signed   poly;
        longint unsigned coef[5];
        bit              neg;
        coef[0] = ((64'd1274147 << 31) + 64'd5000000) / 64'd10000000;
        coef[1] = ((64'd1422483 << 31) + 64'd5000000) / 64'd10000000;
        coef[2] = ((64'd7107068 << 31) + 64'd5000000) / 64'd10000000;
        coef[3] = ((64'd7265759 << 31) + 64'd5000000) / 64'd10000000;
        coef[4] = ((64'd5307027 << 31) + 64'd5000000) / 64'd10000000;
        diff = longint'(pt.sample) - longint'(pt.mean);
        neg  = diff < 0;
        mag  = neg ? longint'(-diff) : longint'(diff);
        sd   = (pt.sdev == 0) ? 64'd1 : 64'(pt.sdev);
        zq28 = ((mag << 28) + sd / 2) / sd;
        if (zq28 > (64'd8 << 28))
            zq28 = 64'd8 << 28;
        az  = (zq28 * (((64'd2316419 << 32) + 64'd5000000) / 64'd10000000) + (64'd1 << 31)) >> 32;
        den = (64'd1 << 28) + az;
        tq  = ((64'd1 << 59) + den / 2) / den;
        // alternating-sign polynomial in t, clamped at zero
        poly = 0;
        pw   = tq;
        for (int k = 0; k < 5; k++) begin
            if (k > 0)
                pw = (pw * tq + Q31_HALF) >> 31;
            term = (coef[k] * pw + Q31_HALF) >> 31;
            poly = (k % 2) ? poly - longint'(term) : poly + longint'(term);
        end
        if (poly < 0)
            poly = 0;
        // exp(-z^2/2) by range reduction on ln2 and a horner series
        wq = (zq28 * zq28) >> 29;
        if (wq >= (64'd22 << 28)) begin
            eq = 0;
        end else begin
            kq  = wq / 64'd186065279;
            r31 = (wq - kq * 64'd186065279) << 3;
            eq  = Q31_ONE;
            for (int n = 12; n >= 1; n--) begin
                prod = (r31 * eq + Q31_HALF) >> 31;
                q    = (prod + 64'(n / 2)) / 64'(n);
                eq   = Q31_ONE - q;
            end
            if (kq > 0)
                eq = (eq + (64'd1 << (kq - 1))) >> kq;
        end
        pe = (longint'(poly) * eq + Q31_HALF) >> 31;
        if (neg)
            return (pe > Q31_ONE) ? 32'h8000_0000 : 32'(pe);
        return (pe > Q31_ONE) ? 32'd0 : 32'(Q31_ONE - pe);
    endfunction

    function automatic t_point mk_point(logic [31:0] s, logic [31:0] m, logic [30:0] d);
        t_point pt;
        pt.sample = s;
        pt.mean   = m;
        pt.sdev   = d;
        return pt;
    endfunction

    // rising edge: record transactions on both sides and check results
    always @(posedge i_clk) begin
        cycles  <= cycles + 1;
        in_took <= i_rst_n && i_in_valid && o_in_ready;
        if (cycles > MAX_CYCLES) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_probs.push_back(cdf_q31(mk_point(i_sample_value, i_mean_value, i_std_dev)));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_probs.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result %h", o_probability);
            end else begin
                logic [31:0] want;
                want = expected_probs.pop_front();
                if (want !== o_probability) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("probability mismatch: expected %h actual %h",
                                 want, o_probability);
                end
            end
        end
    end

    // falling edge: bursty sender, patterned receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || in_took) begin
                if (gap_left > 0 || pending_points.size() == 0) begin
                    if (gap_left > 0)
                        gap_left = gap_left - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    t_point pt;
                    pt = pending_points.pop_front();
                    i_sample_value <= pt.sample;
                    i_mean_value   <= pt.mean;
                    i_std_dev      <= pt.sdev;
                    i_in_valid     <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            // receiver: always ready, random stalls, or long holds
            if (stall_timer == 0) begin
                stall_mode  = $urandom_range(0, 3);
                stall_timer = $urandom_range(20, 300);
            end else begin
                stall_timer = stall_timer - 1;
            end
            case (stall_mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_out_ready <= ((stall_timer % 16) < 3);
                end
            endcase
        end
    end

    initial begin
        logic [30:0] sd;
        int          zoff;
        // directed: zero difference, extremes, tiny deviation, saturation
        pending_points.push_back(mk_point(32'd0, 32'd0, 31'd65536));
        pending_points.push_back(mk_point(32'd65536, 32'd0, 31'd65536));
        pending_points.push_back(mk_point(-32'sd65536, 32'd0, 31'd65536));
        pending_points.push_back(mk_point(32'h7fff_ffff, 32'h8000_0000, 31'd1));
        pending_points.push_back(mk_point(32'h8000_0000, 32'h7fff_ffff, 31'd1));
        pending_points.push_back(mk_point(32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff));
        pending_points.push_back(mk_point(32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff));
        pending_points.push_back(mk_point(32'd1, 32'd0, 31'd1));
        pending_points.push_back(mk_point(32'd0, 32'd1, 31'd1));
        pending_points.push_back(mk_point(32'h1234, 32'h1234, 31'd1));
        pending_points.push_back(mk_point(32'd8 << 16, 32'd0, 31'd65536));
        pending_points.push_back(mk_point(-(32'sd8 << 16), 32'd0, 31'd65536));
        pending_points.push_back(mk_point(32'd9 << 16, 32'd0, 31'd65536));
        pending_points.push_back(mk_point(-(32'sd9 << 16), 32'd0, 31'd65536));
        pending_points.push_back(mk_point(32'd6 << 16, 32'd0, 31'd65536));
        pending_points.push_back(mk_point(32'd32768, 32'd0, 31'h7fff_ffff));
        pending_points.push_back(mk_point(32'hffff_ffff, 32'hffff_ffff, 31'h5555_5555));
        pending_points.push_back(mk_point(32'd5, 32'd0, 31'd2));
        pending_points.push_back(mk_point(-32'sd5, 32'd0, 31'd2));
        // random: mostly |z| in the interesting range, rest unconstrained
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                sd = 31'($urandom());
                if (sd == 0)
                    sd = 31'd1;
                pending_points.push_back(mk_point($urandom(), $urandom(), sd));
            end else begin
                sd   = 31'($urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 28));
                if (sd == 0)
                    sd = 31'd1;
                // offset up to about +-10 deviations, in 1/64 steps
                zoff = int'($urandom_range(0, 1280)) - 640;
                pending_points.push_back(mk_point(0, 0, sd));
                pending_points[$].mean   = $urandom();
                pending_points[$].sample = pending_points[$].mean
                    + 32'((longint'(sd) * zoff) / 64);
            end
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_points.size() == 0 && !i_in_valid && expected_probs.size() == 0);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (mismatches == 0 && expected_probs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

[normal_cdf_approximation.f]
+incdir+design
design/ncdf_pkg.sv
design/ncdf_div.sv
design/ncdf_exp.sv
design/normal_cdf_approximation.sv
sim/testbench.sv
